@@ rtl/kab_pkg.sv @@
// ----------------------------------------------------------------------------
// kab_pkg
// Shared widths, sequencer states, step codes and config register indices for the angle/bias filter.
// ----------------------------------------------------------------------------
package kab_pkg;

    localparam int MCAND_W = 35;             // multiplicand, signed
    localparam int MPLIER_W = 33;            // multiplier, signed, shifted out serially
    localparam int PROD_W = MCAND_W + MPLIER_W;
    localparam int NUM_W = 62;               // |p| << 30
    localparam int DEN_W = 33;               // S, known positive
    localparam int CNT_W = 6;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_PRE  = 8'b0000_0010,
        ST_LOAD = 8'b0000_0100,
        ST_RUN  = 8'b0000_1000,
        ST_RND  = 8'b0001_0000,
        ST_WB   = 8'b0010_0000,
        ST_UPD  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    typedef enum logic [3:0] {
        STEP_ANGLE_PRED = 4'd0,
        STEP_T          = 4'd1,
        STEP_P00_PRED   = 4'd2,
        STEP_P11_PRED   = 4'd3,
        STEP_K0         = 4'd4,
        STEP_K1         = 4'd5,
        STEP_ANGLE_UPD  = 4'd6,
        STEP_BIAS_UPD   = 4'd7,
        STEP_P11_UPD    = 4'd8,
        STEP_P01_UPD    = 4'd9,
        STEP_P10_UPD    = 4'd10,
        STEP_P00_UPD    = 4'd11
    } step_t;

    typedef enum logic [1:0] {
        REG_ANGLE_NOISE = 2'd0,
        REG_BIAS_NOISE  = 2'd1,
        REG_MEAS_NOISE  = 2'd2
    } reg_idx_t;

endpackage

@@ rtl/kalman_angle_bias_filter_top.sv @@
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_top
// Two-state angle/gyro-bias Kalman filter with serial multiply and divide.
// ----------------------------------------------------------------------------
// Sequence: ten serial multiply steps and two serial divide steps per request;
//   both divides are skipped when S is not positive.
// Requests: the next request is taken once the result is registered, later
//   while an older result waits on out_ready; one request is in flight at a time.
// Reset: async active low clears estimates, covariance, handshake; noise regs to defaults.
module kalman_angle_bias_filter_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] measured_angle,
    input  logic signed [31:0] angular_rate,
    input  logic [15:0]        time_step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] filtered_angle,
    output logic               saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AW = kab_pkg::MCAND_W;
    localparam int BW = kab_pkg::MPLIER_W;
    localparam int PW = kab_pkg::PROD_W;
    localparam int SW = 70;

    kab_pkg::state_t state_reg, state_next;
    kab_pkg::step_t  step_reg;

    logic [30:0]        q_angle_reg, q_bias_reg, r_meas_reg;
    logic signed [31:0] ang_reg, bias_reg, rate_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] z_reg, w_reg, ys_reg, k0_reg, k1_reg;
    logic [15:0]        dt_reg;
    logic signed [34:0] inner_reg;
    logic signed [32:0] s_reg;
    logic signed [PW-1:0] rnd_reg;
    logic               sat_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_angle_reg;
    logic               out_sat_reg;

    logic               mul_start, mul_done, div_start, div_done;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_prod;
    logic [kab_pkg::NUM_W-1:0] div_num, div_quo;
    logic signed [31:0] div_p;
    logic [31:0]        div_mag;
    logic               is_div, s_pos, sub_op;
    logic signed [31:0] target;
    logic signed [SW-1:0] wb_sum;
    logic [32:0]        wb_sat;
    logic signed [SW-1:0] k_val;
    logic [32:0]        k_sat;
    logic signed [33:0] t_val;
    logic [32:0]        rate_sat, ys_sat;
    logic [32:0]        p01_t_sat, p10_t_sat;

    function automatic logic [32:0] sat32(input logic signed [SW-1:0] x);
        logic [32:0] r;
        if (x > SW'(64'sh7FFF_FFFF))
            r = {1'b1, 32'h7FFF_FFFF};
        else if (x < -SW'(64'sh8000_0000))
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, x[31:0]};
        return r;
    endfunction

    assign in_ready = (state_reg == kab_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign filtered_angle = out_angle_reg;
    assign saturated = out_sat_reg;

    always_comb
    begin
        is_div = (step_reg == kab_pkg::STEP_K0) || (step_reg == kab_pkg::STEP_K1);
        s_pos = !s_reg[32] && (s_reg != 33'sd0);
        sub_op = (step_reg == kab_pkg::STEP_P11_UPD) || (step_reg == kab_pkg::STEP_P01_UPD)
              || (step_reg == kab_pkg::STEP_P10_UPD) || (step_reg == kab_pkg::STEP_P00_UPD);

        mul_a = AW'(ang_reg);
        mul_b = {17'd0, dt_reg};
        target = ang_reg;
        div_p = p00_reg;
        unique case (step_reg)
            kab_pkg::STEP_ANGLE_PRED: begin mul_a = AW'(rate_reg); end
            kab_pkg::STEP_T:          begin mul_a = AW'(p11_reg); end
            kab_pkg::STEP_P00_PRED:   begin mul_a = inner_reg; target = p00_reg; end
            kab_pkg::STEP_P11_PRED:   begin mul_a = {4'd0, q_bias_reg}; target = p11_reg; end
            kab_pkg::STEP_K0:         begin div_p = p00_reg; end
            kab_pkg::STEP_K1:         begin div_p = p10_reg; end
            kab_pkg::STEP_ANGLE_UPD:
            begin
                mul_a = AW'(ys_reg); mul_b = BW'(k0_reg);
            end
            kab_pkg::STEP_BIAS_UPD:
            begin
                mul_a = AW'(ys_reg); mul_b = BW'(k1_reg); target = bias_reg;
            end
            kab_pkg::STEP_P11_UPD:
            begin
                mul_a = AW'(p01_reg); mul_b = BW'(k1_reg); target = p11_reg;
            end
            kab_pkg::STEP_P01_UPD:
            begin
                mul_a = AW'(p01_reg); mul_b = BW'(k0_reg); target = p01_reg;
            end
            kab_pkg::STEP_P10_UPD:
            begin
                mul_a = AW'(p00_reg); mul_b = BW'(k1_reg); target = p10_reg;
            end
            kab_pkg::STEP_P00_UPD:
            begin
                mul_a = AW'(p00_reg); mul_b = BW'(k0_reg); target = p00_reg;
            end
            default: ;
        endcase

        div_mag = div_p[31] ? 32'(-div_p) : 32'(div_p);
        div_num = {div_mag, 30'd0};

        wb_sum = sub_op ? SW'(target) - SW'(rnd_reg) : SW'(target) + SW'(rnd_reg);
        wb_sat = sat32(wb_sum);
        t_val = 34'(rnd_reg);
        p01_t_sat = sat32(SW'(p01_reg) - SW'(t_val));
        p10_t_sat = sat32(SW'(p10_reg) - SW'(t_val));

        k_val = div_p[31] ? -SW'($signed({1'b0, div_quo})) : SW'($signed({1'b0, div_quo}));
        k_sat = sat32(k_val);

        rate_sat = sat32(SW'(w_reg) - SW'(bias_reg));
        ys_sat = sat32(SW'(z_reg) - SW'(ang_reg));

        mul_start = (state_reg == kab_pkg::ST_LOAD) && !is_div;
        div_start = (state_reg == kab_pkg::ST_LOAD) && is_div && s_pos;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kab_pkg::ST_IDLE: if (in_valid) state_next = kab_pkg::ST_PRE;
            kab_pkg::ST_PRE:  state_next = kab_pkg::ST_LOAD;
            kab_pkg::ST_LOAD:
                state_next = (is_div && !s_pos) ? kab_pkg::ST_WB : kab_pkg::ST_RUN;
            kab_pkg::ST_RUN:
            begin
                if (mul_done)
                    state_next = kab_pkg::ST_RND;
                else if (div_done)
                    state_next = kab_pkg::ST_WB;
            end
            kab_pkg::ST_RND:  state_next = kab_pkg::ST_WB;
            kab_pkg::ST_WB:
            begin
                if (step_reg == kab_pkg::STEP_P11_PRED)
                    state_next = kab_pkg::ST_UPD;
                else if (step_reg == kab_pkg::STEP_P00_UPD)
                    state_next = kab_pkg::ST_DONE;
                else
                    state_next = kab_pkg::ST_LOAD;
            end
            kab_pkg::ST_UPD:  state_next = kab_pkg::ST_LOAD;
            kab_pkg::ST_DONE: if (!out_valid_reg || out_ready) state_next = kab_pkg::ST_IDLE;
            default:          state_next = kab_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kab_pkg::ST_IDLE;
            step_reg      <= kab_pkg::STEP_ANGLE_PRED;
            out_valid_reg <= 1'b0;
            sat_reg       <= 1'b0;
            q_angle_reg   <= 31'd16777;
            q_bias_reg    <= 31'd50332;
            r_meas_reg    <= 31'd503316;
            ang_reg       <= '0;
            bias_reg      <= '0;
            rate_reg      <= '0;
            p00_reg       <= '0;
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    kab_pkg::REG_ANGLE_NOISE: q_angle_reg <= cfg_data[30:0];
                    kab_pkg::REG_BIAS_NOISE:  q_bias_reg <= cfg_data[30:0];
                    kab_pkg::REG_MEAS_NOISE:  r_meas_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end

            if (state_reg == kab_pkg::ST_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                kab_pkg::ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        sat_reg  <= 1'b0;
                        step_reg <= kab_pkg::STEP_ANGLE_PRED;
                    end
                end
                kab_pkg::ST_PRE:
                begin
                    rate_reg <= rate_sat[31:0];
                    sat_reg  <= sat_reg | rate_sat[32];
                end
                kab_pkg::ST_WB:
                begin
                    step_reg <= kab_pkg::step_t'(step_reg + 4'd1);
                    unique case (step_reg)
                        kab_pkg::STEP_ANGLE_PRED, kab_pkg::STEP_ANGLE_UPD:
                        begin
                            ang_reg <= wb_sat[31:0]; sat_reg <= sat_reg | wb_sat[32];
                        end
                        kab_pkg::STEP_BIAS_UPD:
                        begin
                            bias_reg <= wb_sat[31:0]; sat_reg <= sat_reg | wb_sat[32];
                        end
                        kab_pkg::STEP_P00_PRED, kab_pkg::STEP_P00_UPD:
                        begin
                            p00_reg <= wb_sat[31:0]; sat_reg <= sat_reg | wb_sat[32];
                        end
                        kab_pkg::STEP_P11_PRED, kab_pkg::STEP_P11_UPD:
                        begin
                            p11_reg <= wb_sat[31:0]; sat_reg <= sat_reg | wb_sat[32];
                        end
                        kab_pkg::STEP_P01_UPD:
                        begin
                            p01_reg <= wb_sat[31:0]; sat_reg <= sat_reg | wb_sat[32];
                        end
                        kab_pkg::STEP_P10_UPD:
                        begin
                            p10_reg <= wb_sat[31:0]; sat_reg <= sat_reg | wb_sat[32];
                        end
                        kab_pkg::STEP_T:
                        begin
                            // inner term uses the pre-update p01/p10
                            p01_reg <= p01_t_sat[31:0];
                            p10_reg <= p10_t_sat[31:0];
                            sat_reg <= sat_reg | p01_t_sat[32] | p10_t_sat[32];
                        end
                        kab_pkg::STEP_K0, kab_pkg::STEP_K1:
                        begin
                            // non-positive S sets the gain to zero
                            if (s_pos)
                                sat_reg <= sat_reg | k_sat[32];
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase

            if (state_reg == kab_pkg::ST_UPD)
                sat_reg <= sat_reg | ys_sat[32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            z_reg  <= measured_angle;
            w_reg  <= angular_rate;
            dt_reg <= time_step;
        end
        if (state_reg == kab_pkg::ST_RND)
        begin
            if (step_reg < kab_pkg::STEP_ANGLE_UPD)
                rnd_reg <= (mul_prod + PW'(64'sd32768)) >>> 16;
            else
                rnd_reg <= (mul_prod + PW'(64'sd536870912)) >>> 30;
        end
        if (state_reg == kab_pkg::ST_WB && step_reg == kab_pkg::STEP_T)
            inner_reg <= 35'(t_val) - 35'(p01_reg) - 35'(p10_reg) + {4'd0, q_angle_reg};
        if (state_reg == kab_pkg::ST_WB && step_reg == kab_pkg::STEP_K0)
            k0_reg <= s_pos ? k_sat[31:0] : 32'sd0;
        if (state_reg == kab_pkg::ST_WB && step_reg == kab_pkg::STEP_K1)
            k1_reg <= s_pos ? k_sat[31:0] : 32'sd0;
        if (state_reg == kab_pkg::ST_UPD)
        begin
            ys_reg <= ys_sat[31:0];
            s_reg  <= 33'(p00_reg) + {2'b00, r_meas_reg};
        end
        if (state_reg == kab_pkg::ST_DONE && (!out_valid_reg || out_ready))
        begin
            out_angle_reg <= ang_reg;
            out_sat_reg   <= sat_reg;
        end
    end

    kab_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_a),
        .mplier (mul_b),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    kab_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (s_reg[kab_pkg::DEN_W-1:0]),
        .done   (div_done),
        .quo    (div_quo)
    );

endmodule

@@ rtl/kab_mul.sv @@
// ----------------------------------------------------------------------------
// kab_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, sign-magnitude.
// ----------------------------------------------------------------------------
module kab_mul
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [kab_pkg::MCAND_W-1:0]   mcand,
    input  logic signed [kab_pkg::MPLIER_W-1:0]  mplier,
    output logic                                 done,
    output logic signed [kab_pkg::PROD_W-1:0]    prod
);

    localparam int AW = kab_pkg::MCAND_W;
    localparam int BW = kab_pkg::MPLIER_W;
    localparam int PW = kab_pkg::PROD_W;

    logic                          busy_reg;
    logic                          done_reg;
    logic [kab_pkg::CNT_W-1:0]     cnt_reg;
    logic                          neg_reg;
    logic [AW-1:0]                 a_reg;
    logic [PW-1:0]                 p_reg;
    logic signed [PW-1:0]          prod_reg;
    logic [AW:0]                   sum;
    logic [PW-1:0]                 p_next;
    logic                          last;

    always_comb
    begin
        sum = {1'b0, p_reg[PW-1:BW]} + (p_reg[0] ? {1'b0, a_reg} : (AW+1)'(0));
        p_next = {sum, p_reg[BW-1:1]};
        last = (cnt_reg == kab_pkg::CNT_W'(BW - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + kab_pkg::CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= mcand[AW-1] ^ mplier[BW-1];
            a_reg   <= mcand[AW-1] ? AW'(-mcand) : AW'(mcand);
            p_reg   <= {AW'(0), (mplier[BW-1] ? BW'(-mplier) : BW'(mplier))};
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
            if (last)
                prod_reg <= neg_reg ? -$signed(p_next) : $signed(p_next);
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

@@ rtl/kab_div.sv @@
// ----------------------------------------------------------------------------
// kab_div
// Restoring unsigned divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kab_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [kab_pkg::NUM_W-1:0]     num,
    input  logic [kab_pkg::DEN_W-1:0]     den,
    output logic                          done,
    output logic [kab_pkg::NUM_W-1:0]     quo
);

    localparam int NW = kab_pkg::NUM_W;
    localparam int DW = kab_pkg::DEN_W;

    logic                        busy_reg;
    logic                        done_reg;
    logic [kab_pkg::CNT_W-1:0]   cnt_reg;
    logic [NW-1:0]               num_reg;
    logic [DW-1:0]               den_reg;
    logic [DW-1:0]               rem_reg;
    logic [DW:0]                 shifted;
    logic [DW+1:0]               trial;
    logic                        qbit;
    logic                        last;

    always_comb
    begin
        shifted = {rem_reg, num_reg[NW-1]};
        trial = {1'b0, shifted} - {2'b00, den_reg};
        qbit = !trial[DW+1];
        last = (cnt_reg == kab_pkg::CNT_W'(NW - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + kab_pkg::CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift into the bottom of the numerator register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], qbit};
            rem_reg <= qbit ? trial[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo = num_reg;

endmodule
